[design/itr_pkg.sv]
// Shared constants and helpers for the integer-to-radix-digits block.
// No dependencies; imported by the top level, the back end and the checker.
`timescale 1ns / 1ps

package itr_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int OUT_DATA_W     = 8;

	localparam logic [5:0] RADIX_RESET     = 6'd10;
	localparam logic [5:0] RADIX_MIN       = 6'd2;
	localparam logic [5:0] RADIX_MAX       = 6'd36;
	localparam logic [5:0] DIGIT_DEC_LIMIT = 6'd10;

	localparam logic [6:0] CHAR_ZERO        = 7'h30;
	localparam logic [6:0] CHAR_NINE        = 7'h39;
	localparam logic [6:0] CHAR_UPPER_A     = 7'h41;
	localparam logic [6:0] CHAR_UPPER_Z     = 7'h5A;
	localparam logic [6:0] CHAR_MINUS       = 7'h2D;
	localparam logic [6:0] CHAR_LETTER_BASE = 7'h37;

	function automatic logic [5:0] clamp_radix(input logic [5:0] r);
		logic [5:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	function automatic logic [6:0] digit_char(input logic [5:0] d);
		logic [6:0] res;
		if (d < DIGIT_DEC_LIMIT) begin
			res = CHAR_ZERO + {1'b0, d};
		end else begin
			res = CHAR_LETTER_BASE + {1'b0, d};
		end
		return res;
	endfunction

endpackage

[design/itr_front.sv]
// Front end: accepts the input stream, takes sign and magnitude, clamps the
// most negative value. Registered stage feeding the item queue. Uses no package items.
`timescale 1ns / 1ps

module itr_front #(
	parameter int VALUE_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,   // [VALUE_BITS-1:0] value
	output logic                                q_valid,
	input  logic                                q_ready,
	output logic [VALUE_BITS-1:0]               q_data     // {negative, magnitude}
);

	localparam int MAG_BITS = VALUE_BITS - 1;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] raw_neg;
	logic [MAG_BITS-1:0]   mag_c;
	logic                  valid_s1;
	logic [VALUE_BITS-1:0] entry_s1;

	assign raw     = s_tdata[VALUE_BITS-1:0];
	assign raw_neg = (~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1};

	always_comb begin
		if (!raw[VALUE_BITS-1]) begin
			mag_c = raw[MAG_BITS-1:0];
		end else if (raw_neg[VALUE_BITS-1]) begin
			// most negative value: clamp to the largest magnitude
			mag_c = '1;
		end else begin
			mag_c = raw_neg[MAG_BITS-1:0];
		end
	end

	assign s_tready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_data   = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			entry_s1 <= {raw[VALUE_BITS-1], mag_c};
		end
	end

endmodule

[design/itr_queue.sv]
// Two-entry queue between the front end and the conversion back end.
// Generic in width; no package dependencies.
`timescale 1ns / 1ps

module itr_queue #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wvalid,
	output logic             wready,
	input  logic [WIDTH-1:0] wdata,
	output logic             rvalid,
	input  logic             rready,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign wready = (cnt_q != 2'd2);
	assign rvalid = (cnt_q != 2'd0);
	assign rdata  = mem_q[rd_ptr_q];
	assign push   = wvalid && wready;
	assign pop    = rvalid && rready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[design/itr_back.sv]
// Back end: systolic radix conversion over a row of digit lanes, then
// emission of the characters most significant first. Depends on itr_pkg.
`timescale 1ns / 1ps

module itr_back #(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [5:0]            radix,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic [VALUE_BITS-1:0] q_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);

	import itr_pkg::*;

	localparam int MAG_BITS = VALUE_BITS - 1;
	localparam int LANES    = MAG_BITS;
	localparam int CNT_W    = $clog2(MAG_BITS + 1);
	localparam int REM_W    = $clog2(LANES + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [MAG_BITS-1:0] mag_q;
	logic [CNT_W-1:0]    bit_cnt_q;
	logic [LANES-1:1]    en_q;
	logic [LANES-2:0]    carry_q;
	logic [5:0]          digit_q [LANES];
	logic                sign_pend_q;
	logic                lead_done_q;
	logic [REM_W-1:0]    rem_q;
	logic                ovalid_q;
	logic [6:0]          ochar_q;
	logic                olast_q;

	logic [5:0]       radix_eff;
	logic [LANES-1:0] lane_act;
	logic [LANES-1:0] c_in;
	logic [LANES-1:0] c_out;
	logic [5:0]       d_next [LANES];
	logic             conv_busy;
	logic [5:0]       top_digit;
	logic             out_free;
	logic             skip;
	logic             emit;
	logic             shift_up;

	assign radix_eff = clamp_radix(radix);

	// Each lane doubles its digit and adds the carry from the lane below,
	// in the cycle after that lane.
	always_comb begin
		logic [6:0] sum;
		for (int i = 0; i < LANES; i++) begin
			if (i == 0) begin
				lane_act[i] = (bit_cnt_q < CNT_W'(MAG_BITS));
				c_in[i]     = mag_q[MAG_BITS-1];
			end else begin
				lane_act[i] = en_q[i];
				c_in[i]     = carry_q[i-1];
			end
			sum = {digit_q[i], c_in[i]};
			if (sum >= {1'b0, radix_eff}) begin
				d_next[i] = 6'(sum - {1'b0, radix_eff});
				c_out[i]  = 1'b1;
			end else begin
				d_next[i] = sum[5:0];
				c_out[i]  = 1'b0;
			end
		end
	end

	assign conv_busy = lane_act[0] || (|en_q);
	assign top_digit = digit_q[LANES-1];
	assign out_free  = !ovalid_q || m_tready;
	// drop leading zero digits without output; a zero value keeps its last lane
	assign skip      = (state_q == ST_EMIT) && !sign_pend_q && !lead_done_q
		&& (top_digit == 6'd0) && (rem_q != REM_W'(1));
	assign emit      = (state_q == ST_EMIT) && !skip && out_free;
	assign shift_up  = skip || (emit && !sign_pend_q);

	assign q_ready  = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {1'b0, ochar_q};
	assign m_tlast  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			en_q        <= '0;
			sign_pend_q <= 1'b0;
			lead_done_q <= 1'b0;
			rem_q       <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (out_free) begin
				ovalid_q <= emit;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q     <= ST_CONV;
						bit_cnt_q   <= '0;
						en_q        <= '0;
						sign_pend_q <= q_data[VALUE_BITS-1];
						lead_done_q <= 1'b0;
						rem_q       <= REM_W'(LANES);
					end
				end
				ST_CONV: begin
					if (lane_act[0]) begin
						bit_cnt_q <= bit_cnt_q + CNT_W'(1);
					end
					en_q <= {en_q[LANES-2:1], lane_act[0]};
					if (!conv_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit && sign_pend_q) begin
						sign_pend_q <= 1'b0;
					end else if (shift_up) begin
						// once a digit is out, inner zeros are real digits
						if (emit) begin
							lead_done_q <= 1'b1;
						end
						rem_q <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ochar_q <= sign_pend_q ? CHAR_MINUS : digit_char(top_digit);
			olast_q <= !sign_pend_q && (rem_q == REM_W'(1));
		end
		if (state_q == ST_IDLE && q_valid) begin
			mag_q <= q_data[MAG_BITS-1:0];
			for (int i = 0; i < LANES; i++) begin
				digit_q[i] <= 6'd0;
			end
		end else if (state_q == ST_CONV) begin
			if (lane_act[0]) begin
				mag_q <= {mag_q[MAG_BITS-2:0], 1'b0};
			end
			for (int i = 0; i < LANES; i++) begin
				if (lane_act[i]) begin
					digit_q[i] <= d_next[i];
				end
			end
			for (int i = 0; i < LANES - 1; i++) begin
				if (lane_act[i]) begin
					carry_q[i] <= c_out[i];
				end
			end
		end else if (shift_up) begin
			// advance the digit row toward the top lane
			for (int i = LANES - 1; i > 0; i--) begin
				digit_q[i] <= digit_q[i-1];
			end
			digit_q[0] <= 6'd0;
		end
	end

endmodule

[design/integer_to_radix_digits.sv]
// Top level of the integer-to-radix-digits block: radix register, front end,
// queue and back end. Depends on itr_pkg, itr_front, itr_queue and itr_back.
//
//   channel  | direction | payload                       | transaction
//   s_*      | in        | tdata: value                  | s_tvalid && s_tready
//   m_*      | out       | tdata: character, tlast: last | m_tvalid && m_tready
//   cfg_*    | in        | cfg_wdata: radix              | cfg_we
//
// An item is loaded into the back end, passes the lane chain (each lane starts in the
// cycle after the lane below), then drops its leading zero lanes and emits its
// characters, a minus sign first for a negative value. The front end and queue
// take up to three further items meanwhile. Reset clears all control state and
// sets the radix to ten. A stalled output holds the back end; a full queue stalls
// s_tready.
`timescale 1ns / 1ps

module integer_to_radix_digits #(
	parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]             s_tdata,   // value
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [itr_pkg::OUT_DATA_W-1:0]              m_tdata,   // character
	output logic                                        m_tlast,
	input  logic                                        cfg_we,
	input  logic [5:0]                                  cfg_wdata
);

	import itr_pkg::*;

	logic [5:0]            radix_q;
	logic                  fq_valid;
	logic                  fq_ready;
	logic [VALUE_BITS-1:0] fq_data;
	logic                  qb_valid;
	logic                  qb_ready;
	logic [VALUE_BITS-1:0] qb_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	itr_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	itr_queue #(
		.WIDTH (VALUE_BITS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wvalid (fq_valid),
		.wready (fq_ready),
		.wdata  (fq_data),
		.rvalid (qb_valid),
		.rready (qb_ready),
		.rdata  (qb_data)
	);

	itr_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.radix    (radix_q),
		.q_valid  (qb_valid),
		.q_ready  (qb_ready),
		.q_data   (qb_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[design/itr_check.sv]
// Port-level checker for integer_to_radix_digits, attached by bind.
// Depends on itr_pkg for the character codes.
`timescale 1ns / 1ps

module itr_check (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	import itr_pkg::*;

	logic is_minus;
	logic is_legal;

	assign is_minus = (m_tdata == {1'b0, CHAR_MINUS});
	assign is_legal = is_minus
		|| ((m_tdata >= {1'b0, CHAR_ZERO}) && (m_tdata <= {1'b0, CHAR_NINE}))
		|| ((m_tdata >= {1'b0, CHAR_UPPER_A}) && (m_tdata <= {1'b0, CHAR_UPPER_Z}));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> is_legal)
		else $error("character outside sign, digit and letter set");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && is_minus |-> !m_tlast)
		else $error("minus sign closed a run");

	a_minus_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && is_minus |=> !(m_tvalid && is_minus))
		else $error("minus sign repeated");

endmodule

bind integer_to_radix_digits itr_check u_itr_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[tb/sv/tb_integer_to_radix_digits.sv]
// Self-checking testbench for integer_to_radix_digits: stream stimulus, radix register
// writes, and a scoreboard that predicts each character run. Depends on itr_pkg and the DUT.
`timescale 1ns / 1ps

typedef struct packed {
	logic [6:0] ch;
	logic       last;
} radix_char_t;

class digit_text_scoreboard;
	radix_char_t pending[$];
	logic [5:0]  radix_reg;
	int          errors;

	function new();
		radix_reg = itr_pkg::RADIX_RESET;
		errors = 0;
	endfunction

	function void set_radix(logic [5:0] r);
		radix_reg = r;
	endfunction

	// Out-of-range register values act as the nearest legal base.
	function logic [63:0] effective_base();
		logic [63:0] b;
		if (radix_reg < itr_pkg::RADIX_MIN) begin
			b = 64'(itr_pkg::RADIX_MIN);
		end else if (radix_reg > itr_pkg::RADIX_MAX) begin
			b = 64'(itr_pkg::RADIX_MAX);
		end else begin
			b = 64'(radix_reg);
		end
		return b;
	endfunction

	function void note_value(logic [63:0] raw);
		logic [63:0] mag;
		logic [63:0] b;
		logic [5:0]  digits[$];
		logic [6:0]  c;
		logic        neg;
		b = effective_base();
		neg = raw[63];
		mag = neg ? (~raw + 64'd1) : raw;
		// The most negative value has no positive twin; clamp it one step in.
		if (mag[63]) begin
			mag = {1'b0, {63{1'b1}}};
		end
		while (mag != 64'd0) begin
			digits.push_front(6'(mag % b));
			mag = mag / b;
		end
		if (digits.size() == 0) begin
			pending.push_back('{itr_pkg::CHAR_ZERO, 1'b1});
		end else begin
			if (neg) begin
				pending.push_back('{itr_pkg::CHAR_MINUS, 1'b0});
			end
			foreach (digits[i]) begin
				if (digits[i] < itr_pkg::DIGIT_DEC_LIMIT) begin
					c = itr_pkg::CHAR_ZERO + {1'b0, digits[i]};
				end else begin
					c = itr_pkg::CHAR_LETTER_BASE + {1'b0, digits[i]};
				end
				pending.push_back('{c, i == digits.size() - 1});
			end
		end
	endfunction

	function void check_char(logic [7:0] data, logic last);
		radix_char_t want;
		if (pending.size() == 0) begin
			$error("character: expected none, actual %h (last %b)", data, last);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (data !== {1'b0, want.ch}) begin
			$error("character: expected %h, actual %h", {1'b0, want.ch}, data);
			errors++;
		end
		if (last !== want.last) begin
			$error("last: expected %b, actual %b", want.last, last);
			errors++;
		end
	endfunction
endclass

module tb_integer_to_radix_digits;

	localparam int PHASES         = 8;
	localparam int RAND_PER_PHASE = 60;
	localparam int DRAIN_CYCLES   = 200;
	localparam int STALL_LIMIT    = 4000;
	localparam logic [63:0] CORNER_VALUES [8] = '{
		64'd0,
		64'hFFFF_FFFF_FFFF_FFFF,
		64'd35,
		64'd36,
		-64'sd36,
		64'h7FFF_FFFF_FFFF_FFFF,
		64'h8000_0000_0000_0001,
		64'h8000_0000_0000_0000
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;

	int send_idle;
	int recv_idle;
	digit_text_scoreboard sb;

	integer_to_radix_digits dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_value(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				sb.check_char(m_tdata, m_tlast);
			end
		end
	end

	// Entered and left just after a falling edge; hold the value until the transaction.
	task automatic send_value(logic [63:0] v);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = v;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_radix(logic [5:0] r);
		cfg_we = 1'b1;
		cfg_wdata = r;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_radix(r);
	endtask

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		logic [63:0] b;
		int          k;
		b = sb.effective_base();
		case ($urandom_range(0, 5))
			0: v = {$urandom, $urandom};
			1, 2: begin
				k = $urandom_range(1, 63);
				v = {$urandom, $urandom} >> (64 - k);
			end
			3: v = 64'($urandom_range(0, 100));
			4: v = CORNER_VALUES[$urandom_range(0, 7)];
			default: begin
				// Powers of the base and one below them flip the digit count.
				v = 64'd1;
				repeat ($urandom_range(1, 64)) begin
					if (v <= 64'h7FFF_FFFF_FFFF_FFFF / b) begin
						v = v * b;
					end
				end
				v = v - 64'($urandom_range(0, 1));
			end
		endcase
		if ($urandom_range(0, 1)) begin
			v = ~v + 64'd1;
		end
		return v;
	endfunction

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("FAIL integer_to_radix_digits");
		$finish;
	end

	initial begin
		logic [5:0] phase_radix [PHASES];
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 64'd0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 6'd0;
		send_idle = 0;
		recv_idle = 0;
		phase_radix = '{6'd10, 6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37, 6'd10};
		phase_radix[PHASES-1] = 6'($urandom_range(3, 35));
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			// Write the radix only once every run in flight is out.
			while (sb.pending.size() != 0) @(negedge clk);
			if (p < 3) begin
				send_idle = 17;
				recv_idle = 71;
			end else if (p < 6) begin
				send_idle = 71;
				recv_idle = 17;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_radix(phase_radix[p]);
			if (p < 3) begin
				foreach (CORNER_VALUES[i]) begin
					send_value(CORNER_VALUES[i]);
				end
			end
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				send_value(pick_value());
			end
			s_tvalid = 1'b0;
		end

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		while (sb.pending.size() != 0) begin
			$error("character: expected %h, actual none", {1'b0, sb.pending[0].ch});
			void'(sb.pending.pop_front());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("PASS integer_to_radix_digits");
		end else begin
			$display("FAIL integer_to_radix_digits");
		end
		$finish;
	end

endmodule
